@@ sv/slu_pkg.sv @@
// Shared types, character codes and helper functions for the string literal unescape core.
// Used by slu_decode, slu_emit and string_literal_unescape_core; depends on nothing else.
package slu_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_DIGITS
    } t_mode;

    typedef enum logic [2:0] {
        ST_BYTE,
        ST_CLOSED,
        ST_NEWLINE,
        ST_NOT_QUOTE,
        ST_END,
        ST_TOO_LARGE
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          count;
    } t_bundle;

    typedef struct packed {
        logic    emit;
        t_result res;
        t_mode   mode_n;
    } t_body_step;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_UU     = 8'h55;
    localparam logic [7:0] CODE_ESC  = 8'h1B;

    localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;

    localparam t_result RES_NONE = '{data: 8'h00, status: ST_BYTE};

    // Digit value 0..15, or 16 when the byte is no hex digit.
    function automatic logic [4:0] f_hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            d = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
        end else begin
            d = 8'd16;
        end
        return d[4:0];
    endfunction

    // UTF-8 bytes of one code point, or one too-large status.
    function automatic t_bundle f_encode_cp(input logic [31:0] cp);
        t_bundle b;
        b = '{res: {MAX_RESULTS{RES_NONE}}, count: '0};
        if (cp > CP_MAX) begin
            b.res[0] = '{data: 8'h00, status: ST_TOO_LARGE};
            b.count  = CNT_W'(1);
        end else if (cp < 32'h80) begin
            b.res[0] = '{data: cp[7:0], status: ST_BYTE};
            b.count  = CNT_W'(1);
        end else if (cp < 32'h800) begin
            b.res[0] = '{data: {3'b110, cp[10:6]}, status: ST_BYTE};
            b.res[1] = '{data: {2'b10, cp[5:0]}, status: ST_BYTE};
            b.count  = CNT_W'(2);
        end else if (cp < 32'h1_0000) begin
            b.res[0] = '{data: {4'b1110, cp[15:12]}, status: ST_BYTE};
            b.res[1] = '{data: {2'b10, cp[11:6]}, status: ST_BYTE};
            b.res[2] = '{data: {2'b10, cp[5:0]}, status: ST_BYTE};
            b.count  = CNT_W'(3);
        end else begin
            b.res[0] = '{data: {5'b11110, cp[20:18]}, status: ST_BYTE};
            b.res[1] = '{data: {2'b10, cp[17:12]}, status: ST_BYTE};
            b.res[2] = '{data: {2'b10, cp[11:6]}, status: ST_BYTE};
            b.res[3] = '{data: {2'b10, cp[5:0]}, status: ST_BYTE};
            b.count  = CNT_W'(4);
        end
        return b;
    endfunction

    // One byte inside the quotes.
    function automatic t_body_step f_body(input logic [7:0] c, input logic eot,
                                          input logic quote_single);
        t_body_step s;
        logic [7:0] q;
        q = quote_single ? CH_SQUOTE : CH_DQUOTE;
        s = '{emit: 1'b1, res: RES_NONE, mode_n: MODE_BODY};
        if (eot) begin
            s.res    = '{data: 8'h00, status: ST_END};
            s.mode_n = MODE_IDLE;
        end else if (c == q) begin
            s.res    = '{data: 8'h00, status: ST_CLOSED};
            s.mode_n = MODE_IDLE;
        end else if (c == CH_LF || c == CH_CR) begin
            s.res    = '{data: 8'h00, status: ST_NEWLINE};
            s.mode_n = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            s.emit   = 1'b0;
            s.mode_n = MODE_ESC;
        end else begin
            s.res = '{data: c, status: ST_BYTE};
        end
        return s;
    endfunction

endpackage

@@ sv/slu_decode.sv @@
// Literal state registers and the single-pass decode of one byte into a result group.
// Depends on slu_pkg.
module slu_decode
    import slu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_ch,
    input  logic       i_eot,
    output t_bundle    o_bundle
);

    t_mode       r_mode,  n_mode;
    logic        r_quote_single, n_quote_single;
    logic        r_octal, n_octal;
    logic [3:0]  r_left,  n_left;
    logic [31:0] r_accum, n_accum;

    logic        cp_en;
    logic [31:0] cp_sel;
    logic        tail_en;
    t_result     tail;
    logic        use_body;
    t_body_step  body;
    logic [4:0]  digit_v;
    logic [31:0] acc_next;
    t_bundle     enc;
    t_bundle     grp;

    always_comb begin
        n_mode         = r_mode;
        n_quote_single = r_quote_single;
        n_octal        = r_octal;
        n_left         = r_left;
        n_accum        = r_accum;
        cp_en          = 1'b0;
        cp_sel         = r_accum;
        tail_en        = 1'b0;
        tail           = RES_NONE;
        use_body       = 1'b0;

        if (i_eot) begin
            digit_v = 5'd16;
        end else if (r_octal) begin
            digit_v = (i_ch >= CH_0 && i_ch <= CH_7) ? {2'b00, i_ch[2:0]} : 5'd16;
        end else begin
            digit_v = f_hex_value(i_ch);
        end
        acc_next = (r_octal ? {r_accum[28:0], 3'b000} : {r_accum[27:0], 4'h0})
                   + {28'h0, digit_v[3:0]};

        unique case (r_mode)
            MODE_IDLE: begin
                tail_en = 1'b1;
                if (i_eot) begin
                    tail = '{data: 8'h00, status: ST_END};
                end else if (i_ch == CH_DQUOTE || i_ch == CH_SQUOTE) begin
                    tail_en        = 1'b0;
                    n_quote_single = (i_ch == CH_SQUOTE);
                    n_mode         = MODE_BODY;
                end else begin
                    tail = '{data: 8'h00, status: ST_NOT_QUOTE};
                end
            end
            MODE_BODY: begin
                use_body = 1'b1;
            end
            MODE_ESC: begin
                tail_en = 1'b1;
                if (i_eot) begin
                    tail   = '{data: 8'h00, status: ST_END};
                    n_mode = MODE_IDLE;
                end else begin
                    n_mode = MODE_BODY;
                    unique case (i_ch)
                        CH_N:   tail = '{data: CH_LF, status: ST_BYTE};
                        CH_A:   tail = '{data: 8'h07, status: ST_BYTE};
                        CH_E:   tail = '{data: CODE_ESC, status: ST_BYTE};
                        CH_R:   tail = '{data: CH_CR, status: ST_BYTE};
                        CH_T:   tail = '{data: 8'h09, status: ST_BYTE};
                        CH_B:   tail = '{data: 8'h08, status: ST_BYTE};
                        CH_F:   tail = '{data: 8'h0C, status: ST_BYTE};
                        CH_V:   tail = '{data: 8'h0B, status: ST_BYTE};
                        CH_X, CH_U, CH_UU: begin
                            tail_en = 1'b0;
                            n_mode  = MODE_DIGITS;
                            n_octal = 1'b0;
                            n_accum = '0;
                            n_left  = (i_ch == CH_X) ? 4'd2 : (i_ch == CH_U) ? 4'd4 : 4'd8;
                        end
                        default: begin
                            // Backslash, quotes, question mark and unknown letters pass
                            // through as the letter itself.
                            if (i_ch >= CH_0 && i_ch <= CH_7) begin
                                tail_en = 1'b0;
                                n_mode  = MODE_DIGITS;
                                n_octal = 1'b1;
                                n_left  = 4'd2;
                                n_accum = {29'h0, i_ch[2:0]};
                            end else begin
                                tail = '{data: i_ch, status: ST_BYTE};
                            end
                        end
                    endcase
                end
            end
            MODE_DIGITS: begin
                if (!digit_v[4] && r_left != 4'd0) begin
                    n_accum = acc_next;
                    n_left  = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        n_mode = MODE_BODY;
                        cp_en  = 1'b1;
                        cp_sel = acc_next;
                    end
                end else begin
                    // Escape ends early: flush the code point, then treat as body byte.
                    n_mode   = MODE_BODY;
                    cp_en    = 1'b1;
                    use_body = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        body = f_body(i_ch, i_eot, r_quote_single);
        if (use_body) begin
            tail_en = body.emit;
            tail    = body.res;
            n_mode  = body.mode_n;
        end

        enc = f_encode_cp(cp_sel);
        grp = cp_en ? enc : '{res: {MAX_RESULTS{RES_NONE}}, count: '0};
        if (tail_en) begin
            grp.res[grp.count] = tail;
            grp.count          = grp.count + CNT_W'(1);
        end
    end

    assign o_bundle = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_quote_single <= 1'b0;
            r_octal        <= 1'b0;
            r_left         <= 4'd0;
            r_accum        <= 32'h0;
        end else if (i_adv) begin
            r_mode         <= n_mode;
            r_quote_single <= n_quote_single;
            r_octal        <= n_octal;
            r_left         <= n_left;
            r_accum        <= n_accum;
        end
    end

endmodule

@@ sv/slu_emit.sv @@
// Result register: holds one decoded group and sends its results out one per transfer.
// Depends on slu_pkg.
module slu_emit
    import slu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_bundle    i_bundle,
    output logic       o_free,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic [2:0] o_tuser,
    output logic       o_tlast
);

    t_result [MAX_RESULTS-1:0] r_res;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic                      at_last;
    logic                      take;
    t_result                   cur;

    assign at_last  = (r_idx == r_count - CNT_W'(1));
    assign o_tvalid = (r_count != '0);
    assign take     = o_tvalid && i_tready;
    assign o_free   = !o_tvalid || (i_tready && at_last);
    assign cur      = r_res[r_idx];
    assign o_tdata  = cur.data;
    assign o_tuser  = cur.status;
    assign o_tlast  = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_count <= i_bundle.count;
            r_idx   <= '0;
        end else if (take) begin
            if (at_last) begin
                r_count <= '0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end
    end

    ap_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result group loaded over one still in flight");

endmodule

@@ sv/string_literal_unescape_core.sv @@
// Top level of the string literal unescape core: input register, decode, result register.
// Depends on slu_pkg, slu_decode and slu_emit.
//
//  Channel | Direction | tdata            | tuser              | tlast
//  --------+-----------+------------------+--------------------+-------------------------
//  s       | in        | [7:0] ch         | [0] end_of_text    | -
//  m       | out       | [7:0] out_byte   | [2:0] status       | last result of the byte
//
// Each source byte is taken into an input register and decoded into a group of zero to
// five results, which lands in the result register. It sends one result per cycle while
// the output is ready, so plain bytes run at one per cycle; a later group waits until
// the group before has gone out. Bytes that give no result (the opening quote, backslash,
// non-final escape digits) pass through without touching the result register. Reset
// clears the literal state to "awaiting opening quote" and empties both registers.
module string_literal_unescape_core
    import slu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    input  logic [0:0] i_s_tuser,   // [0] end_of_text
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [2:0] o_m_tuser,   // [2:0] status
    output logic       o_m_tlast
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_eot;

    t_bundle dec_bundle;
    logic    dec_has_res;
    logic    emit_free;
    logic    in_move;
    logic    grp_load;

    // Advance a decoded byte when its group fits, or at once when it gives no result.
    assign dec_has_res = (dec_bundle.count != '0);
    assign in_move     = r_in_valid && (emit_free || !dec_has_res);
    assign grp_load    = r_in_valid && dec_has_res && emit_free;
    assign o_s_tready  = !r_in_valid || in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch  <= i_s_tdata;
            r_in_eot <= i_s_tuser[0];
        end
    end

    slu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (in_move),
        .i_ch     (r_in_ch),
        .i_eot    (r_in_eot),
        .o_bundle (dec_bundle)
    );

    slu_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (grp_load),
        .i_bundle (dec_bundle),
        .o_free   (emit_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

    ap_group_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grp_load |=> o_m_tvalid)
        else $error("decoded group did not reach the output");

    ap_move_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move |-> r_in_valid)
        else $error("decode advanced without a held byte");

    ap_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_CLOSED || o_m_tuser == ST_NEWLINE ||
                        o_m_tuser == ST_END || o_m_tuser == ST_NOT_QUOTE)) |-> o_m_tlast)
        else $error("terminating status not marked last");

    ap_status_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_BYTE) |-> (o_m_tdata == 8'h00))
        else $error("status result carries nonzero data");

endmodule
